// ----- hw/rtl/tows_pkg.sv -----
package tows_pkg;

	// Fixed widths of the stream fields and the configuration port.
	localparam int OFFSET_W   = 16;
	localparam int MEAN_W     = 17;
	localparam int SPREAD_W   = 16;
	localparam int TEMPO_W    = 9;
	localparam int LIMIT_W    = 8;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 2;

	// Milliseconds per minute, used to turn beats into ms.
	localparam logic [15:0] MS_PER_MIN = 16'd60000;

	// Reset values of the configuration registers.
	localparam logic [TEMPO_W-1:0] TEMPO_RESET    = 9'd120;
	localparam logic [LIMIT_W-1:0] ON_LIMIT_RESET = 8'd10;
	localparam logic [LIMIT_W-1:0] OFF_LIMIT_RESET = 8'd25;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMPO     = 2'd0,
		REG_ON_LIMIT  = 2'd1,
		REG_OFF_LIMIT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_PUSH  = 1'b0,
		CMD_CLEAR = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		VERDICT_NONE       = 3'd0,
		VERDICT_ON_BEAT    = 3'd1,
		VERDICT_SLIGHT_EARLY = 3'd2,
		VERDICT_SLIGHT_LATE  = 3'd3,
		VERDICT_TOO_EARLY  = 3'd4,
		VERDICT_TOO_LATE   = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		CLASS_ON_BEAT    = 2'd0,
		CLASS_SLIGHT_OFF = 2'd1,
		CLASS_WAY_OFF    = 2'd2
	} class_t;

endpackage

// ----- hw/rtl/tows_ifs.sv -----
interface tows_in_if;
	import tows_pkg::*;

	logic                       valid;
	logic                       ready;
	command_t                   command;
	logic signed [OFFSET_W-1:0] beat_offset;

	modport source (output valid, output command, output beat_offset, input ready);
	modport sink (input valid, input command, input beat_offset, output ready);
endinterface

interface tows_out_if #(
	parameter int CNT_W = 5
);
	import tows_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CNT_W-1:0]         sample_count;
	logic signed [MEAN_W-1:0] mean_ms;
	logic [SPREAD_W-1:0]      spread_ms;
	verdict_t                 verdict;
	class_t                   newest_class;

	modport source (output valid, output sample_count, output mean_ms, output spread_ms,
		output verdict, output newest_class, input ready);
	modport sink (input valid, input sample_count, input mean_ms, input spread_ms,
		input verdict, input newest_class, output ready);
endinterface

// ----- hw/rtl/tows_hist.sv -----
module tows_hist #(
	parameter int DEPTH = 16,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int SUM_W = tows_pkg::OFFSET_W + CNT_W,
	localparam int SQ_W  = 2 * tows_pkg::OFFSET_W - 1 + CNT_W
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [IDX_W-1:0]                     wr_addr,
	input  logic signed [tows_pkg::OFFSET_W-1:0] wr_data,
	input  logic                                 scan_start,
	input  logic [CNT_W-1:0]                     scan_len,
	output logic                                 busy,
	output logic signed [SUM_W-1:0]              sum,
	output logic [SQ_W-1:0]                      sqsum
);
	import tows_pkg::*;

	logic signed [OFFSET_W-1:0] mem [DEPTH];

	logic                       issue_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           len_q;
	logic                       v_s1;
	logic                       v_s2;
	logic signed [OFFSET_W-1:0] rdata_s1;
	logic signed [OFFSET_W-1:0] x_s2;
	logic [2*OFFSET_W-2:0]      sq_s2;
	logic signed [2*OFFSET_W-1:0] prod;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]            sq_q;
	logic [CNT_W-1:0]           cnt_nxt;

	assign cnt_nxt = cnt_q + CNT_W'(1);
	assign prod    = rdata_s1 * rdata_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue_q) begin
			rdata_s1 <= mem[cnt_q[IDX_W-1:0]];
		end
		x_s2  <= rdata_s1;
		sq_s2 <= prod[2*OFFSET_W-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			cnt_q   <= '0;
			len_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sum_q   <= '0;
			sq_q    <= '0;
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			if (scan_start) begin
				issue_q <= (scan_len != '0);
				cnt_q   <= '0;
				len_q   <= scan_len;
				sum_q   <= '0;
				sq_q    <= '0;
			end else begin
				if (issue_q) begin
					cnt_q <= cnt_nxt;
					if (cnt_nxt == len_q) begin
						issue_q <= 1'b0;
					end
				end
				if (v_s2) begin
					sum_q <= sum_q + SUM_W'(x_s2);
					sq_q  <= sq_q + SQ_W'(sq_s2);
				end
			end
		end
	end

	assign busy  = issue_q | v_s1 | v_s2;
	assign sum   = sum_q;
	assign sqsum = sq_q;
endmodule

// ----- hw/rtl/tows_isqrt.sv -----
module tows_isqrt #(
	parameter int X_W = 58,
	localparam int R_W = X_W / 2,
	localparam int ST_W = $clog2(R_W + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [X_W-1:0] x,
	output logic           busy,
	output logic [R_W-1:0] root
);
	logic           busy_q;
	logic [ST_W-1:0] step_q;
	logic [X_W-1:0] x_q;
	logic [R_W+1:0] rem_q;
	logic [R_W-1:0] root_q;
	logic [R_W+1:0] rem_sh;
	logic [R_W+1:0] trial;
	logic           ge;

	// Two radicand bits per step, one root bit per step.
	assign rem_sh = {rem_q[R_W-1:0], x_q[X_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + ST_W'(1);
			if (step_q == ST_W'(R_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[X_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[R_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

// ----- hw/rtl/tows_div.sv -----
module tows_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 14,
	localparam int ST_W = $clog2(NUM_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);
	logic             busy_q;
	logic [ST_W-1:0]  step_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   sh;
	logic [DEN_W:0]   diff;
	logic             ge;

	// Restoring division, one quotient bit per cycle; the quotient
	// shifts in behind the numerator bits.
	assign sh   = {rem_q, num_q[NUM_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + ST_W'(1);
			if (step_q == ST_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = num_q;
endmodule

// ----- hw/rtl/timing_offset_window_stats_top.sv -----
// A clear, or a push while the tempo is zero, goes from S_IDLE straight to S_EMIT.
// A push otherwise runs the window scan and the multipliers, then the bit-serial divider
// (DIV_W = 22 at depth 16) for the newest sample, the mean and, after the root, the spread.
// Throughput: one word in work at a time; a finished word waits in the output register.
// Reset: control state and configuration registers go to their reset values at once;
// the history memory is not cleared, since only entries written since the last clear are read.
module timing_offset_window_stats_top #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tows_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tows_pkg::CFG_W-1:0]     cfg_data,
	tows_in_if.sink                        samples,
	tows_out_if.source                     stats
);
	import tows_pkg::*;

	localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = OFFSET_W + CNT_W;
	localparam int SQ_W   = 2 * OFFSET_W - 1 + CNT_W;
	localparam int D_W    = SQ_W + CNT_W;
	localparam int XR_W   = D_W + 16;
	localparam int X_W    = XR_W + (XR_W % 2);
	localparam int R_W    = X_W / 2;
	// Numerator widths after the 2^15 (mean, sample) and 2^23 (spread) scale is shifted out.
	localparam int MN_W   = SUM_W + 1;
	localparam int SN_W   = R_W - 7;
	localparam int NN_W   = OFFSET_W + 2;
	localparam int DIV_A  = (MN_W > SN_W) ? MN_W : SN_W;
	localparam int DIV_W  = (DIV_A > NN_W) ? DIV_A : NN_W;
	localparam int DEN_W  = CNT_W + TEMPO_W;

	// One-hot sequencer for one item.
	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_SCAN_GO  = 10'b0000000010,
		S_SCAN     = 10'b0000000100,
		S_MUL      = 10'b0000001000,
		S_PREP     = 10'b0000010000,
		S_DIV_NEW  = 10'b0000100000,
		S_DIV_MEAN = 10'b0001000000,
		S_SQ_WAIT  = 10'b0010000000,
		S_DIV_SPR  = 10'b0100000000,
		S_EMIT     = 10'b1000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [TEMPO_W-1:0] tempo_q;
	logic [LIMIT_W-1:0] on_lim_q;
	logic [LIMIT_W-1:0] off_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q   <= TEMPO_RESET;
			on_lim_q  <= ON_LIMIT_RESET;
			off_lim_q <= OFF_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMPO:     tempo_q   <= cfg_data[TEMPO_W-1:0];
				REG_ON_LIMIT:  on_lim_q  <= cfg_data[LIMIT_W-1:0];
				REG_OFF_LIMIT: off_lim_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Ring position and fill count. The ring fills from entry zero after a
	// clear, so while it is not full the held samples sit at entries 0..n-1,
	// and once full every entry is held; the scan always reads 0..n-1.
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;
	logic             stats_q;
	logic signed [OFFSET_W-1:0] v_q;

	logic in_acc;
	logic push;
	assign samples.ready = (state_q == S_IDLE);
	assign in_acc = samples.valid && samples.ready;
	assign push   = in_acc && (samples.command == CMD_PUSH);

	// Window memory and scan.
	logic                    scan_start;
	logic                    scan_busy;
	logic signed [SUM_W-1:0] sum;
	logic [SQ_W-1:0]         sqsum;

	assign scan_start = (state_q == S_SCAN_GO);

	tows_hist #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_addr   (pos_q),
		.wr_data   (samples.beat_offset),
		.scan_start(scan_start),
		.scan_len  (count_q),
		.busy      (scan_busy),
		.sum       (sum),
		.sqsum     (sqsum)
	);

	// Products, one multiplier each, all registered before use.
	logic [D_W-1:0]           nq_s1;
	logic signed [2*SUM_W-1:0] ss_s1;
	logic [MN_W-1:0]          mean_num_q;
	logic [NN_W-1:0]          new_num_q;
	logic [DEN_W-1:0]         nb_q;
	logic                     neg_q;

	logic [SUM_W-1:0]          abs_s;
	logic [SUM_W+15:0]         mean_prod;
	logic [OFFSET_W:0]         abs_v;
	logic [OFFSET_W+16:0]      new_prod;
	logic signed [2*SUM_W-1:0] ss_w;
	logic [D_W-1:0]            nq_w;

	assign abs_s     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	assign mean_prod = abs_s * MS_PER_MIN;
	assign abs_v     = v_q[OFFSET_W-1] ? (OFFSET_W + 1)'(-v_q) : (OFFSET_W + 1)'(v_q);
	assign new_prod  = abs_v * MS_PER_MIN;
	assign ss_w      = sum * sum;
	assign nq_w      = count_q * sqsum;

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			nq_s1      <= nq_w;
			ss_s1      <= ss_w;
			mean_num_q <= mean_prod[SUM_W+15:15];
			new_num_q  <= new_prod[OFFSET_W+16:15];
			nb_q       <= count_q * tempo_q;
			neg_q      <= sum[SUM_W-1];
		end
	end

	// Variance numerator n*Q - S*S, scaled by 2^16 ahead of the root.
	logic [D_W-1:0] d_w;
	logic [X_W-1:0] sq_x;
	logic           sq_start;
	logic           sq_busy;
	logic [R_W-1:0] root;

	assign d_w      = nq_s1 - D_W'(ss_s1);
	assign sq_x     = X_W'({d_w, 16'h0000});
	assign sq_start = (state_q == S_PREP);

	tows_isqrt #(
		.X_W(X_W)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.x     (sq_x),
		.busy  (sq_busy),
		.root  (root)
	);

	// One divider serves the newest sample, the mean and the spread in turn.
	logic [R_W+15:0]  spr_prod;
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_busy;
	logic [DIV_W-1:0] quo;
	logic [DIV_W-1:0] qnew_q;
	logic [DIV_W-1:0] qmean_q;

	assign spr_prod = root * MS_PER_MIN;

	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_W'(new_num_q);
		div_den   = DEN_W'(tempo_q);
		unique case (state_q)
			S_PREP: begin
				div_start = 1'b1;
			end
			S_DIV_NEW: begin
				div_start = !div_busy;
				div_num   = DIV_W'(mean_num_q);
				div_den   = nb_q;
			end
			S_SQ_WAIT: begin
				div_start = !sq_busy;
				div_num   = DIV_W'(spr_prod[R_W+15:23]);
				div_den   = nb_q;
			end
			default: begin
			end
		endcase
	end

	tows_div #(
		.NUM_W(DIV_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quo   (quo)
	);

	// Result assembly from the magnitudes held in qnew_q, qmean_q and the last quotient.
	logic                     ov_q;
	logic                     emit;
	logic [DIV_W-1:0]         mean_full;
	verdict_t                 verdict_w;
	class_t                   class_w;
	logic [DIV_W-1:0]         on_lim_x;
	logic [DIV_W-1:0]         off_lim_x;

	assign on_lim_x  = DIV_W'(on_lim_q);
	assign off_lim_x = DIV_W'(off_lim_q);
	assign mean_full = neg_q ? (~qmean_q + DIV_W'(1)) : qmean_q;
	assign emit      = (state_q == S_EMIT) && (!ov_q || stats.ready);

	always_comb begin
		priority if (qnew_q <= on_lim_x) begin
			class_w = CLASS_ON_BEAT;
		end else if (qnew_q <= off_lim_x) begin
			class_w = CLASS_SLIGHT_OFF;
		end else begin
			class_w = CLASS_WAY_OFF;
		end
		// A zero mean always lands on beat, so the sign only matters for a nonzero magnitude.
		priority if (qmean_q <= on_lim_x) begin
			verdict_w = VERDICT_ON_BEAT;
		end else if (qmean_q <= off_lim_x) begin
			verdict_w = neg_q ? VERDICT_SLIGHT_EARLY : VERDICT_SLIGHT_LATE;
		end else begin
			verdict_w = neg_q ? VERDICT_TOO_EARLY : VERDICT_TOO_LATE;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV_NEW && !div_busy) begin
			qnew_q <= quo;
		end
		if (state_q == S_DIV_MEAN && !div_busy) begin
			qmean_q <= quo;
		end
		if (in_acc) begin
			v_q <= samples.beat_offset;
		end
		if (emit) begin
			stats.sample_count <= count_q;
			if (stats_q) begin
				stats.mean_ms      <= mean_full[MEAN_W-1:0];
				stats.spread_ms    <= quo[SPREAD_W-1:0];
				stats.verdict      <= verdict_w;
				stats.newest_class <= class_w;
			end else begin
				stats.mean_ms      <= '0;
				stats.spread_ms    <= '0;
				stats.verdict      <= VERDICT_NONE;
				stats.newest_class <= CLASS_ON_BEAT;
			end
		end
	end

	assign stats.valid = ov_q;

	// Sequencer, ring pointers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			count_q <= '0;
			stats_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (stats.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (samples.command == CMD_CLEAR) begin
							pos_q   <= '0;
							count_q <= '0;
							stats_q <= 1'b0;
							state_q <= S_EMIT;
						end else begin
							pos_q <= (pos_q == IDX_W'(HISTORY_DEPTH - 1)) ?
								'0 : pos_q + IDX_W'(1);
							if (count_q != CNT_W'(HISTORY_DEPTH)) begin
								count_q <= count_q + CNT_W'(1);
							end
							stats_q <= (tempo_q != '0);
							state_q <= (tempo_q != '0) ? S_SCAN_GO : S_EMIT;
						end
					end
				end
				S_SCAN_GO:  state_q <= S_SCAN;
				S_SCAN: begin
					if (!scan_busy) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:      state_q <= S_PREP;
				S_PREP:     state_q <= S_DIV_NEW;
				S_DIV_NEW: begin
					if (!div_busy) begin
						state_q <= S_DIV_MEAN;
					end
				end
				S_DIV_MEAN: begin
					if (!div_busy) begin
						state_q <= S_SQ_WAIT;
					end
				end
				S_SQ_WAIT: begin
					if (!sq_busy) begin
						state_q <= S_DIV_SPR;
					end
				end
				S_DIV_SPR: begin
					if (!div_busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
